[src/gpio_pkg.sv]
// Shared constants, register codes, item types and helpers of the GPIO port block.
`timescale 1ns / 1ps

package gpio_pkg;

	// Block size.
	localparam int NUM_PORTS     = 8;
	localparam int PINS_PER_PORT = 16;

	// Field widths of the input and result items.
	localparam int FUNC_W  = 2;
	localparam int PORT_W  = 3;
	localparam int SEL_W   = 4;
	localparam int DATA_W  = 32;
	localparam int LEVEL_W = 16;
	localparam int IRQ_W   = 8;

	// Derived widths.
	localparam int PAIR_W     = 2 * PINS_PER_PORT;
	localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int CLR_LSB    = 16;

	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic [SEL_W-1:0]         sel_t;
	typedef logic [PINS_PER_PORT-1:0] pins_t;
	typedef logic [PAIR_W-1:0]        pairs_t;
	typedef logic [PORT_IDX_W-1:0]    port_idx_t;

	// Item kinds.
	localparam func_t FUNC_WRITE  = 2'd0;
	localparam func_t FUNC_READ   = 2'd1;
	localparam func_t FUNC_SAMPLE = 2'd2;

	// Register selectors.
	localparam sel_t REG_MUX     = 4'd0;
	localparam sel_t REG_PULL    = 4'd1;
	localparam sel_t REG_DIR     = 4'd2;
	localparam sel_t REG_DATA    = 4'd3;
	localparam sel_t REG_SETCLR  = 4'd4;
	localparam sel_t REG_IRQMODE = 4'd5;
	localparam sel_t REG_STATUS  = 4'd6;
	localparam sel_t REG_PENDING = 4'd7;
	localparam sel_t REG_WAKE    = 4'd8;

	// One input item.
	typedef struct packed {
		func_t               func;
		logic [PORT_W-1:0]   port;
		sel_t                reg_sel;
		logic [DATA_W-1:0]   wdata;
		logic [LEVEL_W-1:0]  pin_levels;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [DATA_W-1:0]   rdata;
		logic [IRQ_W-1:0]    port_irq;
		logic                wake_request;
		logic [LEVEL_W-1:0]  out_levels;
		logic [LEVEL_W-1:0]  out_enable;
	} result_t;

	// Pins whose two-bit mode has the selected bit set (0 rising, 1 falling).
	function automatic pins_t mode_pins(pairs_t mode, logic falling);
		pins_t r;
		for (int i = 0; i < PINS_PER_PORT; i++) begin
			r[i] = falling ? mode[2*i+1] : mode[2*i];
		end
		return r;
	endfunction

	// Pins with any edge enabled.
	function automatic pins_t irq_pins(pairs_t mode);
		return mode_pins(mode, 1'b0) | mode_pins(mode, 1'b1);
	endfunction

endpackage

[src/gpio_ifs.sv]
// Valid/ready channel interfaces for the GPIO request and result items.
`timescale 1ns / 1ps

interface gpio_req_if;
	logic                           valid;
	logic                           ready;
	logic [gpio_pkg::FUNC_W-1:0]    func;
	logic [gpio_pkg::PORT_W-1:0]    port;
	logic [gpio_pkg::SEL_W-1:0]     reg_sel;
	logic [gpio_pkg::DATA_W-1:0]    wdata;
	logic [gpio_pkg::LEVEL_W-1:0]   pin_levels;

	modport source (output valid, func, port, reg_sel, wdata, pin_levels, input ready);
	modport sink (input valid, func, port, reg_sel, wdata, pin_levels, output ready);
endinterface

interface gpio_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [gpio_pkg::DATA_W-1:0]    rdata;
	logic [gpio_pkg::IRQ_W-1:0]     port_irq;
	logic                           wake_request;
	logic [gpio_pkg::LEVEL_W-1:0]   out_levels;
	logic [gpio_pkg::LEVEL_W-1:0]   out_enable;

	modport source (output valid, rdata, port_irq, wake_request, out_levels, out_enable,
		input ready);
	modport sink (input valid, rdata, port_irq, wake_request, out_levels, out_enable,
		output ready);
endinterface

[src/gpio_regs.sv]
// Per-port register file, edge detection and result logic of the GPIO block.
`timescale 1ns / 1ps

module gpio_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  gpio_pkg::item_t   item,
	output gpio_pkg::result_t result
);

	// Per-port state.
	gpio_pkg::pairs_t alt_mux_q     [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  pull_up_q     [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  input_dir_q   [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  out_latch_q   [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  in_sample_q   [gpio_pkg::NUM_PORTS];
	gpio_pkg::pairs_t irq_mode_q    [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  irq_status_q  [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  wake_enable_q [gpio_pkg::NUM_PORTS];

	logic                 hit;
	gpio_pkg::port_idx_t  idx;

	gpio_pkg::pairs_t cur_mux, cur_mode;
	gpio_pkg::pins_t  cur_pull, cur_dir, cur_out, cur_in, cur_status, cur_wake;
	gpio_pkg::pairs_t nxt_mux, nxt_mode;
	gpio_pkg::pins_t  nxt_pull, nxt_dir, nxt_out, nxt_in, nxt_status, nxt_wake;

	gpio_pkg::pins_t  w_pins, w_clr, levels, rise, fall;
	gpio_pkg::pairs_t w_pairs;
	logic             cur_line;

	gpio_pkg::pairs_t all_mode   [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  all_status [gpio_pkg::NUM_PORTS];
	gpio_pkg::pins_t  all_wake   [gpio_pkg::NUM_PORTS];
	logic [gpio_pkg::IRQ_W-1:0] irq_vec;
	logic             wake_any;
	logic [gpio_pkg::DATA_W-1:0] rd_val;

	// Address decode and current state of the addressed port.
	assign hit = ({1'b0, item.port} < (gpio_pkg::PORT_W + 1)'(gpio_pkg::NUM_PORTS));
	assign idx = item.port[gpio_pkg::PORT_IDX_W-1:0];

	assign cur_mux    = alt_mux_q[idx];
	assign cur_pull   = pull_up_q[idx];
	assign cur_dir    = input_dir_q[idx];
	assign cur_out    = out_latch_q[idx];
	assign cur_in     = in_sample_q[idx];
	assign cur_mode   = irq_mode_q[idx];
	assign cur_status = irq_status_q[idx];
	assign cur_wake   = wake_enable_q[idx];

	// Operand slices.
	assign w_pins  = item.wdata[gpio_pkg::PINS_PER_PORT-1:0];
	assign w_clr   = item.wdata[gpio_pkg::CLR_LSB +: gpio_pkg::PINS_PER_PORT];
	assign w_pairs = item.wdata[gpio_pkg::PAIR_W-1:0];
	assign levels  = item.pin_levels[gpio_pkg::PINS_PER_PORT-1:0];
	assign rise    = levels & ~cur_in;
	assign fall    = cur_in & ~levels;

	// Next state of the addressed port.
	always_comb begin
		nxt_mux    = cur_mux;
		nxt_pull   = cur_pull;
		nxt_dir    = cur_dir;
		nxt_out    = cur_out;
		nxt_in     = cur_in;
		nxt_mode   = cur_mode;
		nxt_status = cur_status;
		nxt_wake   = cur_wake;
		if (hit && item.func == gpio_pkg::FUNC_WRITE) begin
			case (item.reg_sel)
				gpio_pkg::REG_MUX:     nxt_mux = w_pairs;
				gpio_pkg::REG_PULL:    nxt_pull = w_pins;
				gpio_pkg::REG_DIR:     nxt_dir = w_pins;
				gpio_pkg::REG_DATA:    nxt_out = w_pins;
				gpio_pkg::REG_SETCLR:  nxt_out = (cur_out & ~w_clr) | w_pins;
				gpio_pkg::REG_IRQMODE: nxt_mode = w_pairs;
				gpio_pkg::REG_STATUS:  nxt_status = cur_status & ~w_pins;
				gpio_pkg::REG_WAKE:    nxt_wake = w_pins;
				default:               ;
			endcase
		end else if (hit && item.func == gpio_pkg::FUNC_SAMPLE) begin
			nxt_in     = levels;
			nxt_status = cur_status |
				(rise & gpio_pkg::mode_pins(cur_mode, 1'b0)) |
				(fall & gpio_pkg::mode_pins(cur_mode, 1'b1));
		end
	end

	// Interrupt lines and wake request after the update, over every port.
	always_comb begin
		irq_vec  = '0;
		wake_any = 1'b0;
		for (int q = 0; q < gpio_pkg::NUM_PORTS; q++) begin
			if (hit && idx == gpio_pkg::PORT_IDX_W'(q)) begin
				all_mode[q]   = nxt_mode;
				all_status[q] = nxt_status;
				all_wake[q]   = nxt_wake;
			end else begin
				all_mode[q]   = irq_mode_q[q];
				all_status[q] = irq_status_q[q];
				all_wake[q]   = wake_enable_q[q];
			end
			irq_vec[q] = |(all_status[q] & gpio_pkg::irq_pins(all_mode[q]));
			wake_any   = wake_any | (|(all_status[q] & all_wake[q]));
		end
	end

	// Read data; reads do not change state, so the current values serve.
	assign cur_line = |(cur_status & gpio_pkg::irq_pins(cur_mode));

	always_comb begin
		rd_val = '0;
		if (hit && item.func == gpio_pkg::FUNC_READ) begin
			case (item.reg_sel)
				gpio_pkg::REG_MUX:     rd_val = gpio_pkg::DATA_W'(cur_mux);
				gpio_pkg::REG_PULL:    rd_val = gpio_pkg::DATA_W'(cur_pull);
				gpio_pkg::REG_DIR:     rd_val = gpio_pkg::DATA_W'(cur_dir);
				gpio_pkg::REG_DATA:    rd_val = {gpio_pkg::LEVEL_W'(cur_in),
					gpio_pkg::LEVEL_W'(cur_out)};
				gpio_pkg::REG_IRQMODE: rd_val = gpio_pkg::DATA_W'(cur_mode);
				gpio_pkg::REG_STATUS:  rd_val = gpio_pkg::DATA_W'(cur_status);
				gpio_pkg::REG_PENDING: rd_val = gpio_pkg::DATA_W'(cur_line);
				gpio_pkg::REG_WAKE:    rd_val = gpio_pkg::DATA_W'(cur_wake);
				default:               rd_val = '0;
			endcase
		end
	end

	// Result item.
	always_comb begin
		result.rdata        = rd_val;
		result.port_irq     = irq_vec;
		result.wake_request = wake_any;
		result.out_levels   = hit ? gpio_pkg::LEVEL_W'(nxt_out) : '0;
		result.out_enable   = hit ? gpio_pkg::LEVEL_W'(~nxt_dir) : '0;
	end

	// State update of the addressed port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < gpio_pkg::NUM_PORTS; p++) begin
				alt_mux_q[p]     <= '0;
				pull_up_q[p]     <= '0;
				input_dir_q[p]   <= '1;
				out_latch_q[p]   <= '0;
				in_sample_q[p]   <= '0;
				irq_mode_q[p]    <= '0;
				irq_status_q[p]  <= '0;
				wake_enable_q[p] <= '0;
			end
		end else if (en && hit) begin
			alt_mux_q[idx]     <= nxt_mux;
			pull_up_q[idx]     <= nxt_pull;
			input_dir_q[idx]   <= nxt_dir;
			out_latch_q[idx]   <= nxt_out;
			in_sample_q[idx]   <= nxt_in;
			irq_mode_q[idx]    <= nxt_mode;
			irq_status_q[idx]  <= nxt_status;
			wake_enable_q[idx] <= nxt_wake;
		end
	end

endmodule

[src/gpio_port_with_edge_interrupts.sv]
// Top level of the GPIO port block: input register, register file and result register.
//
//   channel | dir | item
//   --------+-----+------------------------------------------------------------
//   req     | in  | func, port, reg_sel, wdata, pin_levels
//   rsp     | out | rdata, port_irq, wake_request, out_levels, out_enable
//
// One item per clock sustained while rsp is not stalled; a result is offered on rsp once its item has
// passed the input register into the result register. The addressed port's registers update in the same
// cycle the result is registered, so the next item in the input register already sees them.
// Reset clears all port registers but the directions, which reset to inputs.
// A stalled rsp holds the result; req still takes an item while the input register is empty.
`timescale 1ns / 1ps

module gpio_port_with_edge_interrupts (
	input  logic            clk,
	input  logic            arst_n,
	gpio_req_if.sink        req,
	gpio_rsp_if.source      rsp
);

	logic              valid_s1;
	gpio_pkg::item_t   item_s1;
	logic              out_valid_q;
	gpio_pkg::result_t result_q;
	gpio_pkg::result_t result_d;
	logic              advance;

	// The item in the input register moves on when the result register is free.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.func       <= req.func;
			item_s1.port       <= req.port;
			item_s1.reg_sel    <= req.reg_sel;
			item_s1.wdata      <= req.wdata;
			item_s1.pin_levels <= req.pin_levels;
		end
	end

	// Register file and result logic.
	gpio_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.rdata        = result_q.rdata;
	assign rsp.port_irq     = result_q.port_irq;
	assign rsp.wake_request = result_q.wake_request;
	assign rsp.out_levels   = result_q.out_levels;
	assign rsp.out_enable   = result_q.out_enable;

endmodule

[test/testbench.sv]
// Self-checking testbench of the GPIO port block with edge interrupts.
`timescale 1ns / 1ps

module testbench;
	import gpio_pkg::*;

	localparam func_t FUNC_UNUSED = 2'd3;
	localparam int    RANDOM_ITEMS_PER_PHASE = 380;
	localparam int    DRAIN_CYCLES = 10;
	localparam int    CYCLE_LIMIT  = 200000;

	// Shadow copy of the register file; predicts one result per accepted item.
	class gpio_shadow;
		pairs_t    alt_mux     [NUM_PORTS];
		pins_t     pull_up     [NUM_PORTS];
		pins_t     input_dir   [NUM_PORTS];
		pins_t     out_latch   [NUM_PORTS];
		pins_t     in_sample   [NUM_PORTS];
		pairs_t    irq_mode    [NUM_PORTS];
		pins_t     irq_status  [NUM_PORTS];
		pins_t     wake_enable [NUM_PORTS];
		result_t   expected_results[$];
		int        errors;

		function new();
			for (int p = 0; p < NUM_PORTS; p++) begin
				alt_mux[p]     = '0;
				pull_up[p]     = '0;
				input_dir[p]   = '1;
				out_latch[p]   = '0;
				in_sample[p]   = '0;
				irq_mode[p]    = '0;
				irq_status[p]  = '0;
				wake_enable[p] = '0;
			end
			errors = 0;
		endfunction

		// Pins whose mode has the rising (0) or falling (1) bit set.
		function pins_t edge_enables(pairs_t mode, bit falling);
			pins_t en;
			for (int i = 0; i < PINS_PER_PORT; i++) begin
				en[i] = mode[2*i + int'(falling)];
			end
			return en;
		endfunction

		function bit port_line(int p);
			return |(irq_status[p] & (edge_enables(irq_mode[p], 1'b0) |
				edge_enables(irq_mode[p], 1'b1)));
		endfunction

		function result_t predict_result(item_t it);
			result_t r;
			bit      in_range;
			int      p;
			pins_t   now_levels;
			pins_t   rise;
			pins_t   fall;
			r = '0;
			in_range = it.port < NUM_PORTS;
			p = in_range ? int'(it.port) : 0;
			if (in_range) begin
				case (it.func)
					FUNC_WRITE: begin
						case (it.reg_sel)
							REG_MUX:     alt_mux[p]     = pairs_t'(it.wdata);
							REG_PULL:    pull_up[p]     = pins_t'(it.wdata);
							REG_DIR:     input_dir[p]   = pins_t'(it.wdata);
							REG_DATA:    out_latch[p]   = pins_t'(it.wdata);
							REG_SETCLR: begin
								out_latch[p] = (out_latch[p] & ~pins_t'(it.wdata[31:16])) |
									pins_t'(it.wdata[15:0]);
							end
							REG_IRQMODE: irq_mode[p]    = pairs_t'(it.wdata);
							REG_STATUS:  irq_status[p]  = irq_status[p] & ~pins_t'(it.wdata);
							REG_WAKE:    wake_enable[p] = pins_t'(it.wdata);
							default: ;
						endcase
					end
					FUNC_READ: begin
						case (it.reg_sel)
							REG_MUX:     r.rdata = DATA_W'(alt_mux[p]);
							REG_PULL:    r.rdata = DATA_W'(pull_up[p]);
							REG_DIR:     r.rdata = DATA_W'(input_dir[p]);
							REG_DATA: begin
								r.rdata = (DATA_W'(in_sample[p]) << 16) | DATA_W'(out_latch[p]);
							end
							REG_IRQMODE: r.rdata = DATA_W'(irq_mode[p]);
							REG_STATUS:  r.rdata = DATA_W'(irq_status[p]);
							REG_PENDING: r.rdata = DATA_W'(port_line(p));
							REG_WAKE:    r.rdata = DATA_W'(wake_enable[p]);
							default:     r.rdata = '0;
						endcase
					end
					FUNC_SAMPLE: begin
						now_levels = pins_t'(it.pin_levels);
						rise = now_levels & ~in_sample[p];
						fall = in_sample[p] & ~now_levels;
						in_sample[p] = now_levels;
						irq_status[p] = irq_status[p] |
							(rise & edge_enables(irq_mode[p], 1'b0)) |
							(fall & edge_enables(irq_mode[p], 1'b1));
					end
					default: ;
				endcase
			end
			// Summary outputs are taken after the update.
			for (int q = 0; q < NUM_PORTS; q++) begin
				if (port_line(q))
					r.port_irq[q] = 1'b1;
				if (|(irq_status[q] & wake_enable[q]))
					r.wake_request = 1'b1;
			end
			r.out_levels = in_range ? LEVEL_W'(out_latch[p]) : '0;
			r.out_enable = in_range ? LEVEL_W'(~input_dir[p]) : '0;
			return r;
		endfunction

		function void note_item(item_t it);
			expected_results.push_back(predict_result(it));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report("result with no item outstanding", got.rdata, '0);
			end else begin
				want = expected_results.pop_front();
				if (got.rdata !== want.rdata)
					report("rdata", got.rdata, want.rdata);
				if (got.port_irq !== want.port_irq)
					report("port_irq", 32'(got.port_irq), 32'(want.port_irq));
				if (got.wake_request !== want.wake_request)
					report("wake_request", 32'(got.wake_request), 32'(want.wake_request));
				if (got.out_levels !== want.out_levels)
					report("out_levels", 32'(got.out_levels), 32'(want.out_levels));
				if (got.out_enable !== want.out_enable)
					report("out_enable", 32'(got.out_enable), 32'(want.out_enable));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         cycle_count;
	pins_t      last_levels [8];
	gpio_shadow shadow = new();

	gpio_req_if req_ch ();
	gpio_rsp_if rsp_ch ();

	gpio_port_with_edge_interrupts u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("gpio_port_with_edge_interrupts verification failed");
		$finish;
	end

	// Result side: random back-pressure and checking of every accepted result.
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			shadow.check_result({rsp_ch.rdata, rsp_ch.port_irq, rsp_ch.wake_request,
				rsp_ch.out_levels, rsp_ch.out_enable});
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one item, with random idle cycles ahead of it, and waits for its acceptance.
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= it.func;
		req_ch.port       <= it.port;
		req_ch.reg_sel    <= it.reg_sel;
		req_ch.wdata      <= it.wdata;
		req_ch.pin_levels <= it.pin_levels;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		shadow.note_item(it);
	endtask

	task automatic send_fields(func_t f, int port, sel_t sel, logic [31:0] w, pins_t levels);
		item_t it;
		it.func       = f;
		it.port       = PORT_W'(port);
		it.reg_sel    = sel;
		it.wdata      = w;
		it.pin_levels = LEVEL_W'(levels);
		send_item(it);
	endtask

	// Holds the request channel idle until every outstanding result has come back.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed accesses; pin samples mostly toggle a few pins to make edges.
	function automatic item_t random_item();
		item_t it;
		int    pick;
		it.port = PORT_W'($urandom_range((1 << PORT_W) - 1));
		pick = $urandom_range(99);
		if (pick < 36)
			it.func = FUNC_SAMPLE;
		else if (pick < 66)
			it.func = FUNC_READ;
		else if (pick < 96)
			it.func = FUNC_WRITE;
		else
			it.func = FUNC_UNUSED;
		if ($urandom_range(99) < 90)
			it.reg_sel = sel_t'($urandom_range(REG_WAKE));
		else
			it.reg_sel = sel_t'($urandom_range((1 << SEL_W) - 1, REG_WAKE + 1));
		pick = $urandom_range(99);
		if (pick < 10)
			it.wdata = '1;
		else if (pick < 20)
			it.wdata = '0;
		else
			it.wdata = $urandom;
		pick = $urandom_range(99);
		if (pick < 60)
			it.pin_levels = last_levels[it.port] ^ LEVEL_W'($urandom & $urandom & $urandom);
		else if (pick < 90)
			it.pin_levels = LEVEL_W'($urandom);
		else
			it.pin_levels = last_levels[it.port];
		if (it.func == FUNC_SAMPLE)
			last_levels[it.port] = it.pin_levels;
		return it;
	endfunction

	// Stimulus.
	initial begin
		arst_n            = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		req_ch.valid      = 1'b0;
		req_ch.func       = FUNC_READ;
		req_ch.port       = '0;
		req_ch.reg_sel    = REG_MUX;
		req_ch.wdata      = '0;
		req_ch.pin_levels = '0;
		rsp_ch.ready      = 1'b0;
		for (int p = 0; p < 8; p++)
			last_levels[p] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register extremes, set and clear together, edges and mode changes.
		send_fields(FUNC_READ,   0, REG_DIR,     '0, '0);
		send_fields(FUNC_WRITE,  0, REG_MUX,     '1, '0);
		send_fields(FUNC_READ,   0, REG_MUX,     '0, '0);
		send_fields(FUNC_WRITE,  0, REG_PULL,    '1, '0);
		send_fields(FUNC_READ,   0, REG_PULL,    '0, '0);
		send_fields(FUNC_WRITE,  0, REG_DIR,     '0, '0);
		send_fields(FUNC_WRITE,  0, REG_DATA,    '1, '0);
		send_fields(FUNC_WRITE,  0, REG_SETCLR,  32'hFF00_0F0F, '0);
		send_fields(FUNC_READ,   0, REG_SETCLR,  '0, '0);
		send_fields(FUNC_WRITE,  7, REG_IRQMODE, 32'h5555_5555, '0);
		send_fields(FUNC_WRITE,  7, REG_WAKE,    '1, '0);
		send_fields(FUNC_SAMPLE, 7, REG_MUX,     '0, '1);
		send_fields(FUNC_READ,   7, REG_STATUS,  '0, '0);
		send_fields(FUNC_READ,   7, REG_PENDING, '0, '0);
		send_fields(FUNC_WRITE,  7, REG_PENDING, '1, '0);
		send_fields(FUNC_WRITE,  7, REG_IRQMODE, '0, '0);
		send_fields(FUNC_READ,   7, REG_PENDING, '0, '0);
		send_fields(FUNC_WRITE,  7, REG_IRQMODE, 32'hAAAA_AAAA, '0);
		send_fields(FUNC_SAMPLE, 7, REG_MUX,     '0, '0);
		send_fields(FUNC_WRITE,  7, REG_STATUS,  '1, '0);
		send_fields(FUNC_READ,   7, REG_DATA,    '0, '0);
		send_fields(FUNC_WRITE,  3, sel_t'((1 << SEL_W) - 1), '1, '0);
		send_fields(FUNC_READ,   3, sel_t'(REG_WAKE + 1), '0, '0);
		send_fields(FUNC_UNUSED, 3, REG_DATA,    '1, '1);
		send_fields(FUNC_READ,   0, REG_DATA,    '0, '0);
		wait_for_results();

		// Random phases with different idling on the two sides.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
				3:       begin send_idle_pct = 36; recv_stall_pct = 36; end
				default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase
			for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
				send_item(random_item());
			wait_for_results();
		end

		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending() == 0) begin
			$display("gpio_port_with_edge_interrupts verification clean");
		end else begin
			$display("gpio_port_with_edge_interrupts verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
src/gpio_pkg.sv
src/gpio_ifs.sv
src/gpio_regs.sv
src/gpio_port_with_edge_interrupts.sv
test/testbench.sv
